>>> hw/rtl/tlv_pkg.sv
package tlv_pkg;

   typedef enum logic [1:0] {
      PH_TAG     = 2'd0,
      PH_LEN     = 2'd1,
      PH_VAL     = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic [1:0] CLS_TAG     = 2'd0;
   localparam logic [1:0] CLS_LEN     = 2'd1;
   localparam logic [1:0] CLS_VAL     = 2'd2;
   localparam logic [1:0] CLS_DISCARD = 2'd3;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;

   typedef struct packed {
      logic        op;
      logic [7:0]  data_byte;
      logic [15:0] buffer_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  byte_class;
      logic [15:0] record_tag;
      logic [15:0] record_length;
      logic [15:0] value_offset;
      logic        record_end;
      logic [1:0]  error_code;
      logic        buffer_end;
   } rsp_type;

endpackage

>>> hw/rtl/tlv_stream_parser_core.sv
// path: a req is held in the input register, its result in the result register that drives rsp
// throughput: one item per cycle unless rsp stalls, begin items and bytes outside a buffer give no rsp
// rsp stall backs up through the input register into req_stall
// reset: synchronous, active high; clears valids, parse phase and bytes remaining
module tlv_stream_parser_core
   import tlv_pkg::*;
#(
   parameter int TAG_BYTES = 2,
   parameter int LEN_BYTES = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam logic [1:0] TagBytesW = 2'(TAG_BYTES);
   localparam logic [1:0] LenBytesW = 2'(LEN_BYTES);

   logic        in_valid_ff;
   req_type     in_item_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_item_ff;

   phase_type   phase_ff, phase_in;
   logic        fbc_ff, fbc_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] vcnt_ff, vcnt_in;
   logic [15:0] remain_ff, remain_in;

   logic        out_free;
   logic        res_valid;
   logic        s1_adv;
   logic        out_load;
   rsp_type     res;
   logic [15:0] left;
   logic [15:0] shifted;
   logic        field_done;
   logic [1:0]  fbc_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = in_valid_ff && (!res_valid || out_free);
   assign out_load  = s1_adv && res_valid;
   assign req_stall = in_valid_ff && !s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // one item through the parse state
   always_comb begin
      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      vcnt_in    = vcnt_ff;
      remain_in  = remain_ff;
      res_valid  = 1'b0;
      res        = '0;
      left       = remain_ff - 16'd1;
      shifted    = fbc_ff ? {in_item_ff.data_byte, 8'h00} : {8'h00, in_item_ff.data_byte};
      fbc_next   = {1'b0, fbc_ff} + 2'd1;
      field_done = 1'b0;
      if (in_item_ff.op == OP_BEGIN) begin
         phase_in  = PH_TAG;
         fbc_in    = 1'b0;
         tag_in    = '0;
         len_in    = '0;
         vcnt_in   = '0;
         remain_in = in_item_ff.buffer_length;
      end else if (remain_ff != 16'd0) begin
         res_valid       = 1'b1;
         res.buffer_end  = (remain_ff == 16'd1);
         res.error_code  = ERR_NONE;
         remain_in       = left;
         unique case (phase_ff)
            PH_TAG: begin
               res.byte_class = CLS_TAG;
               if (!fbc_ff) begin
                  tag_in  = shifted;
                  len_in  = '0;
                  vcnt_in = '0;
               end else begin
                  tag_in = tag_ff | shifted;
               end
               field_done = (fbc_next >= TagBytesW);
               fbc_in     = field_done ? 1'b0 : fbc_next[0];
               if (field_done) begin
                  phase_in = PH_LEN;
               end
               if (res.buffer_end) begin
                  res.error_code = ERR_TRUNCATED;
               end
            end
            PH_LEN: begin
               res.byte_class = CLS_LEN;
               len_in         = len_ff | shifted;
               field_done     = (fbc_next >= LenBytesW);
               fbc_in         = field_done ? 1'b0 : fbc_next[0];
               if (field_done) begin
                  vcnt_in = '0;
                  priority if (len_in > left) begin
                     res.error_code = ERR_TOO_LONG;
                     phase_in       = PH_DISCARD;
                  end else if (len_in == 16'd0) begin
                     res.record_end = 1'b1;
                     phase_in       = PH_TAG;
                  end else begin
                     phase_in = PH_VAL;
                  end
               end else if (res.buffer_end) begin
                  res.error_code = ERR_TRUNCATED;
               end
            end
            PH_VAL: begin
               res.byte_class   = CLS_VAL;
               res.value_offset = vcnt_ff;
               vcnt_in          = vcnt_ff + 16'd1;
               if (vcnt_in == len_ff) begin
                  res.record_end = 1'b1;
                  phase_in       = PH_TAG;
               end
            end
            PH_DISCARD: begin
               res.byte_class = CLS_DISCARD;
            end
            default: begin
               res.byte_class = CLS_DISCARD;
            end
         endcase
      end
      res.record_tag    = tag_in;
      res.record_length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_TAG;
         fbc_ff       <= 1'b0;
         tag_ff       <= '0;
         len_ff       <= '0;
         vcnt_ff      <= '0;
         remain_ff    <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            phase_ff  <= phase_in;
            fbc_ff    <= fbc_in;
            tag_ff    <= tag_in;
            len_ff    <= len_in;
            vcnt_ff   <= vcnt_in;
            remain_ff <= remain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
      if (out_load) begin
         rsp_item_ff <= res;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("held rsp item overwritten");

   a_discard_sticks: assert property (@(posedge clock) disable iff (reset)
      (out_load && phase_ff == PH_DISCARD) |=> (rsp_item.byte_class == CLS_DISCARD))
      else $error("byte after length error not discarded");

   a_no_bytes_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && remain_ff == 16'd0) |-> !out_load)
      else $error("rsp made for byte outside a buffer");

   a_last_byte_drains: assert property (@(posedge clock) disable iff (reset)
      (out_load && remain_ff == 16'd1) |=> (remain_ff == 16'd0 || phase_ff == PH_TAG))
      else $error("buffer end did not drain byte count");

endmodule
